// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== rtl/core/arpr_pkg.sv =====
// types, constants and byte helpers of the arp request responder
`default_nettype none

package arpr_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [5:0] ARP_LEN = 6'd42;
  localparam logic [5:0] HDR_LEN = 6'd22;

  localparam logic [47:0] OWN_MAC_RESET = 48'h010203040506;
  localparam logic [31:0] OWN_IP_RESET  = 32'hC0A8FE01;

  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  localparam logic [3:0] V_REPLY = 4'd0;
  localparam logic [3:0] V_SHORT = 4'd1;
  localparam logic [3:0] V_DEST  = 4'd2;
  localparam logic [3:0] V_ETYPE = 4'd3;
  localparam logic [3:0] V_HTYPE = 4'd4;
  localparam logic [3:0] V_PTYPE = 4'd5;
  localparam logic [3:0] V_HLEN  = 4'd6;
  localparam logic [3:0] V_PLEN  = 4'd7;
  localparam logic [3:0] V_OP    = 4'd8;
  localparam logic [3:0] V_TMAC  = 4'd9;
  localparam logic [3:0] V_TIP   = 4'd10;

  localparam logic [7:0] HDR_EXPECT [22] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };

  localparam logic [3:0] HDR_CODE [22] = '{
    V_DEST, V_DEST, V_DEST, V_DEST, V_DEST, V_DEST,
    V_REPLY, V_REPLY, V_REPLY, V_REPLY, V_REPLY, V_REPLY,
    V_ETYPE, V_ETYPE, V_HTYPE, V_HTYPE, V_PTYPE, V_PTYPE, V_HLEN, V_PLEN, V_OP, V_OP
  };

  localparam logic [7:0] REPLY_MID [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  typedef struct packed {
    logic [3:0]  verdict;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
  } job_t;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
    logic [7:0] b;
    unique case (i)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] reply_at(input logic [5:0] p, input job_t job,
                                          input logic [47:0] own_mac,
                                          input logic [31:0] own_ip);
    logic [5:0] off;
    logic [7:0] b;
    off = 6'd0;
    b   = 8'h00;
    if (p < 6'd6) begin
      b = mac_byte(job.peer_mac, p[2:0]);
    end else if (p < 6'd12) begin
      off = p - 6'd6;
      b   = mac_byte(own_mac, off[2:0]);
    end else if (p < 6'd22) begin
      off = p - 6'd12;
      b   = REPLY_MID[off[3:0]];
    end else if (p < 6'd28) begin
      off = p - 6'd22;
      b   = mac_byte(own_mac, off[2:0]);
    end else if (p < 6'd32) begin
      off = p - 6'd28;
      b   = ip_byte(own_ip, off[1:0]);
    end else if (p < 6'd38) begin
      off = p - 6'd32;
      b   = mac_byte(job.peer_mac, off[2:0]);
    end else if (p < 6'd42) begin
      off = p - 6'd38;
      b   = ip_byte(job.peer_ip, off[1:0]);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/arp_request_responder.sv =====
// arp request responder top level: config registers, receive checker, job queue, reply sender
//
// s_* carries a received ethernet frame, one byte per beat, tlast on the final
// byte. m_* carries the result: for a valid arp request aimed at own_ip, the
// 42-byte arp reply (tuser 0, tlast on byte 41); otherwise one beat with the
// verdict code in tuser, tdata 0 and tlast set. frames shorter than 42 bytes
// always give the short verdict.
// input takes one byte per cycle while the job queue has room; the first
// result beat passes through the job queue, the current-job register and the
// output register, and results then leave at one beat per cycle while m_tready
// is high. the receive side and the transmit side meet in a job queue of
// QUEUE_DEPTH entries; s_tready drops only while that queue is full, which is
// what throttles input when the downstream sink stalls. a stalled m_tready
// holds the output beat, and receiving continues until the queue fills.
// cfg_we writes own_mac (index 0) or own_ip (index 1) from cfg_data. synchronous
// reset empties the queue and the output, restarts frame parsing and loads the default addresses.
`default_nettype none

module arp_request_responder import arpr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // frame_byte
  input  wire logic        s_tlast,   // frame_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // reply_byte
  output logic             m_tlast,   // reply_end
  output logic [3:0]       m_tuser,   // verdict
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data
);

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic        full;
  logic        push;
  job_t        push_job;
  logic        pop;
  logic        head_valid;
  job_t        head;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= OWN_MAC_RESET;
      own_ip  <= OWN_IP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_MAC: own_mac <= cfg_data;
        CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        default:     own_mac <= own_mac;
      endcase
    end
  end

  arpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .own_ip   (own_ip),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  arpr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  arpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .own_mac    (own_mac),
    .own_ip     (own_ip),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/core/arpr_front.sv =====
// receive side: checks frame bytes and queues one job per frame
`default_nettype none

module arpr_front import arpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // frame_byte
  input  wire logic        s_tlast,   // frame_last
  input  wire logic [31:0] own_ip,
  input  wire logic        full,
  output logic             push,
  output job_t             push_job
);

  logic [5:0]  pos, pos_next;
  logic [3:0]  first_fault, first_fault_next;
  logic        tz, tz_next;
  logic        to, to_next;
  logic [47:0] peer_mac, peer_mac_next;
  logic [31:0] peer_ip, peer_ip_next;
  logic [3:0]  fault_code;
  logic [5:0]  ip_off;
  logic [4:0]  hdr_idx;
  logic        accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    pos_next      = pos;
    tz_next       = tz;
    to_next       = to;
    peer_mac_next = peer_mac;
    peer_ip_next  = peer_ip;
    fault_code    = V_REPLY;
    ip_off        = pos - 6'd38;
    hdr_idx       = pos[4:0];
    if (pos < ARP_LEN) begin
      pos_next = pos + 6'd1;
      if (pos < HDR_LEN) begin
        if (HDR_CODE[hdr_idx] != V_REPLY && s_tdata != HDR_EXPECT[hdr_idx]) begin
          fault_code = HDR_CODE[hdr_idx];
        end
        if (pos >= 6'd6 && pos < 6'd12) begin
          peer_mac_next = {peer_mac[39:0], s_tdata};
        end
      end else if (pos >= 6'd28 && pos < 6'd32) begin
        peer_ip_next = {peer_ip[23:0], s_tdata};
      end else if (pos >= 6'd32 && pos < 6'd38) begin
        tz_next = tz && (s_tdata == 8'h00);
        to_next = to && (s_tdata == 8'hFF);
        if (pos == 6'd37 && !tz_next && !to_next) begin
          fault_code = V_TMAC;
        end
      end else if (pos >= 6'd38) begin
        if (s_tdata != ip_byte(own_ip, ip_off[1:0])) begin
          fault_code = V_TIP;
        end
      end
    end
    first_fault_next = (first_fault == V_REPLY) ? fault_code : first_fault;
  end

  assign push              = accept && s_tlast;
  assign push_job.verdict  = (pos_next < ARP_LEN) ? V_SHORT : first_fault_next;
  assign push_job.peer_mac = peer_mac_next;
  assign push_job.peer_ip  = peer_ip_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 6'd0;
      first_fault <= V_REPLY;
      tz          <= 1'b1;
      to          <= 1'b1;
      peer_mac    <= 48'd0;
      peer_ip     <= 32'd0;
    end else if (accept) begin
      peer_mac <= peer_mac_next;
      peer_ip  <= peer_ip_next;
      if (s_tlast) begin
        pos         <= 6'd0;
        first_fault <= V_REPLY;
        tz          <= 1'b1;
        to          <= 1'b1;
      end else begin
        pos         <= pos_next;
        first_fault <= first_fault_next;
        tz          <= tz_next;
        to          <= to_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/arpr_fifo.sv =====
// short job queue between the receive and transmit sides
`default_nettype none

`include "assert_macros.svh"

module arpr_fifo import arpr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && !head_valid)
  `ASSERT_PROP(a_count_step, clk, rst, (push && !pop) |=> (count == $past(count) + CNT_W'(1)))

endmodule

`default_nettype wire

// ===== rtl/core/arpr_back.sv =====
// transmit side: turns queued jobs into reply beats or a verdict beat
`default_nettype none

`include "assert_macros.svh"

module arpr_back import arpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [47:0] own_mac,
  input  wire logic [31:0] own_ip,
  input  wire logic        head_valid,
  input  job_t             head,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // reply_byte
  output logic             m_tlast,   // reply_end
  output logic [3:0]       m_tuser    // verdict
);

  logic       cur_valid;
  job_t       cur;
  logic [5:0] cnt;
  logic       out_free;
  logic       emit;
  logic       job_done;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = out_free && cur_valid;
  assign job_done = (cur.verdict != V_REPLY) || (cnt == ARP_LEN - 6'd1);
  assign pop      = head_valid && (!cur_valid || (emit && job_done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= 6'd0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= cur_valid;
      end
      if (emit) begin
        if (job_done) begin
          cnt <= 6'd0;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (emit && job_done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      if (cur.verdict == V_REPLY) begin
        m_tdata <= reply_at(cnt, cur, own_mac, own_ip);
        m_tlast <= (cnt == ARP_LEN - 6'd1);
        m_tuser <= V_REPLY;
      end else begin
        m_tdata <= 8'h00;
        m_tlast <= 1'b1;
        m_tuser <= cur.verdict;
      end
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt >= ARP_LEN)
  `ASSERT_PROP(a_verdict_last, clk, rst, (m_tvalid && m_tuser != V_REPLY) |-> (m_tlast && m_tdata == 8'h00))
  `ASSERT_PROP(a_idle_cnt, clk, rst, !cur_valid |-> (cnt == 6'd0))

endmodule

`default_nettype wire

// ===== verif/tb_arp_request_responder.sv =====
// testbench for arp_request_responder: directed and random frames checked against a byte-level predictor
`default_nettype none

module tb_arp_request_responder;
  import arpr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_BYTES    = 12;
  localparam int REQ_LEN         = 42;

  localparam logic [47:0] BOOT_MAC = 48'h010203040506;
  localparam logic [31:0] BOOT_IP  = 32'hC0A8FE01;

  localparam logic [7:0] HDR_WANT [22] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };
  localparam logic [3:0] HDR_FAULT [22] = '{
    V_DEST, V_DEST, V_DEST, V_DEST, V_DEST, V_DEST,
    V_REPLY, V_REPLY, V_REPLY, V_REPLY, V_REPLY, V_REPLY,
    V_ETYPE, V_ETYPE, V_HTYPE, V_HTYPE, V_PTYPE, V_PTYPE, V_HLEN, V_PLEN, V_OP, V_OP
  };
  localparam logic [7:0] REPLY_BODY [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
    logic [3:0] verdict;
  } reply_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // frame_byte
  logic        s_tlast;   // frame_last
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // reply_byte
  logic        m_tlast;   // reply_end
  logic [3:0]  m_tuser;   // verdict
  logic        cfg_we;
  logic        cfg_index;
  logic [47:0] cfg_data;

  arp_request_responder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // responder model state
  logic [47:0] mac_cfg;
  logic [31:0] ip_cfg;
  int          rx_pos;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [3:0]  fault_code;
  logic        tgt_zero;
  logic        tgt_ones;
  reply_beat_t reply_beats_due [$];

  logic [7:0] frame_q [$];
  int         burst_left;
  int         hold_off_req;
  int         mismatches;
  int         beats_checked;
  int         frames_sent;
  int         stall_cycles;
  int         idle_cycles;
  int         verdict_hits [16];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] reply_octet(input int k);
    if (k < 6) return sender_mac[8*(5-k) +: 8];
    if (k < 12) return mac_cfg[8*(11-k) +: 8];
    if (k < 22) return REPLY_BODY[k-12];
    if (k < 28) return mac_cfg[8*(27-k) +: 8];
    if (k < 32) return ip_cfg[8*(31-k) +: 8];
    if (k < 38) return sender_mac[8*(37-k) +: 8];
    return sender_ip[8*(41-k) +: 8];
  endfunction

  function automatic void note_fault(input logic [3:0] code);
    if (fault_code == V_REPLY) fault_code = code;
  endfunction

  function automatic void restart_frame();
    rx_pos     = 0;
    fault_code = V_REPLY;
    tgt_zero   = 1'b1;
    tgt_ones   = 1'b1;
  endfunction

  function automatic void track_rx_octet(input logic [7:0] b, input logic last);
    reply_beat_t r;
    int k;
    if (rx_pos < REQ_LEN) begin
      if (rx_pos < 22) begin
        if (HDR_FAULT[rx_pos] != V_REPLY && b != HDR_WANT[rx_pos]) note_fault(HDR_FAULT[rx_pos]);
        if (rx_pos >= 6 && rx_pos < 12) sender_mac = {sender_mac[39:0], b};
      end else if (rx_pos >= 28 && rx_pos < 32) begin
        sender_ip = {sender_ip[23:0], b};
      end else if (rx_pos >= 32 && rx_pos < 38) begin
        if (b != 8'h00) tgt_zero = 1'b0;
        if (b != 8'hFF) tgt_ones = 1'b0;
        if (rx_pos == 37 && !tgt_zero && !tgt_ones) note_fault(V_TMAC);
      end else if (rx_pos >= 38) begin
        if (b != ip_cfg[8*(41-rx_pos) +: 8]) note_fault(V_TIP);
      end
      rx_pos++;
    end
    if (last) begin
      if (rx_pos < REQ_LEN || fault_code != V_REPLY) begin
        r.data    = 8'h00;
        r.tail    = 1'b1;
        r.verdict = (rx_pos < REQ_LEN) ? V_SHORT : fault_code;
        reply_beats_due.push_back(r);
      end else begin
        for (k = 0; k < REQ_LEN; k++) begin
          r.data    = reply_octet(k);
          r.tail    = (k == REQ_LEN - 1);
          r.verdict = V_REPLY;
          reply_beats_due.push_back(r);
        end
      end
      restart_frame();
    end
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_octet(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_rx_octet(b, last);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_idle();
    s_tvalid <= 1'b0;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_octet(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic settle();
    send_idle();
    while (reply_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_MAC) mac_cfg = val;
    else ip_cfg = val[31:0];
    @(negedge clk);
  endtask

  function automatic logic [47:0] any_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic build_request(input logic [47:0] smac, input logic [31:0] sip,
                               input bit tgt_all_ones, input int len);
    int i;
    frame_q.delete();
    for (i = 0; i < 6; i++) frame_q.push_back(8'hFF);
    for (i = 0; i < 6; i++) frame_q.push_back(smac[8*(5-i) +: 8]);
    for (i = 12; i < 22; i++) frame_q.push_back(HDR_WANT[i]);
    for (i = 0; i < 6; i++) frame_q.push_back(8'($urandom));
    for (i = 0; i < 4; i++) frame_q.push_back(sip[8*(3-i) +: 8]);
    for (i = 0; i < 6; i++) frame_q.push_back(tgt_all_ones ? 8'hFF : 8'h00);
    for (i = 0; i < 4; i++) frame_q.push_back(ip_cfg[8*(3-i) +: 8]);
    while (frame_q.size() < len) frame_q.push_back(8'($urandom));
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endtask

  task automatic build_random_request(input int len);
    build_request(any_mac(), $urandom, 1'($urandom_range(0, 1)), len);
  endtask

  task automatic spoil(input int p);
    frame_q[p] = frame_q[p] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic test_reply_defaults();
    // a little past the request length so the position counter has to hold
    build_random_request(REQ_LEN + 2);
    send_frame();
    settle();
  endtask

  task automatic test_short_frames();
    frame_q.delete();
    frame_q.push_back(8'h00);
    send_frame();
    frame_q.delete();
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hFF);
    send_frame();
    // short verdict wins over a failed check
    build_random_request(5);
    spoil(0);
    send_frame();
    settle();
  endtask

  task automatic test_register_extremes();
    int checks [16] = '{0, 5, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 32, 37, 38, 41};
    write_reg(CFG_OWN_MAC, {48{1'b1}});
    write_reg(CFG_OWN_IP, 48'h0);
    // first failed check is the one reported, target ip against the new own_ip
    build_random_request(REQ_LEN);
    spoil(checks[$urandom_range(0, 15)]);
    spoil(REQ_LEN - 1);
    send_frame();
    settle();
  endtask

  task automatic test_backpressure();
    int i;
    hold_off_req = HOLD_OFF_CYCLES;
    wait (hold_off_req == 0);
    @(negedge clk);
    for (i = 0; i < 6; i++) begin
      frame_q.delete();
      frame_q.push_back(8'($urandom));
      send_frame();
    end
    settle();
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    int i;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      len = $urandom_range(1, 4);
      frame_q.delete();
      for (i = 0; i < len; i++) frame_q.push_back(8'($urandom));
      send_frame();
      sent += len;
    end
    settle();
  endtask

  // receiver: stalls on its own changing pattern, with one long hold-off on request
  initial begin : sink
    int mode;
    int mode_left;
    int hold;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        hold         = hold_off_req;
        hold_off_req = 0;
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    reply_beat_t want;
    if (!rst && s_tvalid && !s_tready) stall_cycles++;
    if (!rst && m_tvalid && m_tready) begin
      if (reply_beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, got byte %h end %b verdict %0d",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = reply_beats_due.pop_front();
        if (m_tdata !== want.data || m_tlast !== want.tail || m_tuser !== want.verdict) begin
          mismatches++;
          $display("%0t: beat mismatch, expected byte %h end %b verdict %0d, got byte %h end %b verdict %0d",
                   $time, want.data, want.tail, want.verdict, m_tdata, m_tlast, m_tuser);
        end
      end
      beats_checked++;
      if (!$isunknown(m_tuser)) verdict_hits[m_tuser]++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d beats still due",
                 $time, WATCHDOG_LIMIT, reply_beats_due.size());
        $display("FAIL arp_request_responder");
        $finish;
      end
    end
  end

  initial begin : run
    int kinds;
    int v;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tlast       = 1'b0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_OWN_MAC;
    cfg_data      = 48'h0;
    mac_cfg       = BOOT_MAC;
    ip_cfg        = BOOT_IP;
    sender_mac    = 48'h0;
    sender_ip     = 32'h0;
    burst_left    = 0;
    hold_off_req  = 0;
    mismatches    = 0;
    beats_checked = 0;
    frames_sent   = 0;
    stall_cycles  = 0;
    idle_cycles   = 0;
    for (v = 0; v < 16; v++) verdict_hits[v] = 0;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reply_defaults();
    test_short_frames();
    test_register_extremes();
    test_backpressure();
    test_random_frames();

    while (reply_beats_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    kinds = 0;
    for (v = 0; v < 16; v++) if (verdict_hits[v] != 0) kinds++;
    $display("sent %0d frames, checked %0d result beats covering %0d verdict kinds",
             frames_sent, beats_checked, kinds);
    $display("input held back for %0d cycles by a full reply queue", stall_cycles);
    if (mismatches == 0) begin
      $display("PASS arp_request_responder");
    end else begin
      $display("FAIL arp_request_responder");
    end
    $finish;
  end

endmodule

`default_nettype wire
